[src/rmq_pkg.sv]
// Shared types and constants of the rotation matrix to quaternion pipeline.
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int DW         = 16;  // matrix element and quaternion field width
  localparam int N2W        = 62;  // squared norm after normalization, [2^60, 2^62)
  localparam int NRMW       = 31;  // norm, [2^30, 2^31)
  localparam int VMW        = 31;  // component magnitude after normalization
  localparam int QW         = 17;  // quotient bits kept before saturation
  localparam int NORM_STEPS = 5;   // pair shifts of 16, 8, 4, 2, 1
  localparam int SQRT_STEPS = 31;  // one root bit per stage
  localparam int DIV_LAT    = QW + 1;

  typedef logic [1:0] branch_t;

  localparam branch_t BR_TRACE = 2'd0;
  localparam branch_t BR_X     = 2'd1;
  localparam branch_t BR_Y     = 2'd2;
  localparam branch_t BR_Z     = 2'd3;

  // Per-item flags that ride alongside the data
  typedef struct packed {
    logic       deg;
    branch_t    br;
    logic [3:0] neg;
  } side_t;

endpackage

[src/rmq_ifs.sv]
// Handshake channels: matrix input and quaternion output.
`timescale 1ns / 1ps

interface rmq_mat_if;
  logic valid;
  logic ready;
  logic signed [rmq_pkg::DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rmq_quat_if;
  logic valid;
  logic ready;
  logic signed [rmq_pkg::DW-1:0] quat_w, quat_x, quat_y, quat_z;
  rmq_pkg::branch_t branch_used;
  logic degenerate;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, branch_used, degenerate,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, branch_used, degenerate,
                  output ready);
endinterface

[src/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix to unit quaternion, fully pipelined.
`timescale 1ns / 1ps

//  channel | dir | payload                                         | handshake
//  --------+-----+-------------------------------------------------+-------------
//  mat     | in  | m00..m22, signed Q2.14                          | valid/ready
//  quat    | out | quat_w..quat_z signed Q2.14, branch_used, degen.| valid/ready
//
//  One item per cycle while quat does not stall; the pipeline is: branch pick,
//  abs, squares, norm sum, 5 normalize steps, 31 square-root bit stages,
//  18 divider stages and the output register.
//  Reset (rst, synchronous) clears only the stage valid bits.
//  A stall on quat freezes every stage at once while the output holds an item;
//  bubbles in flight are frozen too, and nothing is dropped or repeated.

module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  rmq_mat_if.sink            mat,
  rmq_quat_if.source         quat
);

  localparam int DW   = rmq_pkg::DW;
  localparam int N2W  = rmq_pkg::N2W;
  localparam int NRMW = rmq_pkg::NRMW;
  localparam int VMW  = rmq_pkg::VMW;
  localparam int QW   = rmq_pkg::QW;
  localparam int NST  = rmq_pkg::NORM_STEPS;
  localparam int SST  = rmq_pkg::SQRT_STEPS;
  localparam int LAT  = 4 + NST + SST + rmq_pkg::DIV_LAT + 1;

  // signed width holding the branch argument and the element sums/differences
  localparam int AW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int MW  = AW - 1;
  localparam int SQW = 2 * MW;

  localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

  logic en;
  logic        vv [1:LAT];
  rmq_pkg::side_t sd [1:LAT-1];

  // whole pipe moves unless the output holds an untaken item
  assign en        = !vv[LAT] || quat.ready;
  assign mat.ready = en;

  // ---------------- stage A: branch, argument, vector ----------------
  logic signed [AW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [AW-1:0] trace;
  logic signed [AW-1:0] vc [4];
  logic signed [AW-1:0] arg_c;
  rmq_pkg::branch_t     br_c;
  rmq_pkg::side_t       side_c;

  assign e00 = AW'(mat.m00);
  assign e01 = AW'(mat.m01);
  assign e02 = AW'(mat.m02);
  assign e10 = AW'(mat.m10);
  assign e11 = AW'(mat.m11);
  assign e12 = AW'(mat.m12);
  assign e20 = AW'(mat.m20);
  assign e21 = AW'(mat.m21);
  assign e22 = AW'(mat.m22);
  assign trace = e00 + e11 + e22;

  always_comb begin
    priority if (trace > 0) begin
      br_c  = rmq_pkg::BR_TRACE;
      arg_c = ONE + trace;
      vc[0] = arg_c;      vc[1] = e21 - e12; vc[2] = e02 - e20; vc[3] = e10 - e01;
    end else if (e00 > e11 && e00 > e22) begin
      br_c  = rmq_pkg::BR_X;
      arg_c = ONE + e00 - e11 - e22;
      vc[0] = e21 - e12;  vc[1] = arg_c;     vc[2] = e01 + e10; vc[3] = e02 + e20;
    end else if (e11 > e22) begin
      br_c  = rmq_pkg::BR_Y;
      arg_c = ONE + e11 - e00 - e22;
      vc[0] = e02 - e20;  vc[1] = e01 + e10; vc[2] = arg_c;     vc[3] = e12 + e21;
    end else begin
      br_c  = rmq_pkg::BR_Z;
      arg_c = ONE + e22 - e00 - e11;
      vc[0] = e10 - e01;  vc[1] = e02 + e20; vc[2] = e12 + e21; vc[3] = arg_c;
    end
    side_c.deg = (arg_c <= 0);
    side_c.br  = br_c;
    for (int i = 0; i < 4; i++) side_c.neg[i] = vc[i][AW-1];
  end

  logic signed [AW-1:0] a_v [4];
  logic [MW-1:0]        b_m [4];
  logic [SQW-1:0]       c_sq [4];
  logic [N2W-1:0]       d_n2;
  logic [VMW-1:0]       d_m [4];
  logic [VMW-1:0]       c_m [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a_v[i]  <= vc[i];
        // magnitude; the top bit of the signed value is never needed
        b_m[i]  <= a_v[i][AW-1] ? MW'(-a_v[i]) : MW'(a_v[i]);
        c_sq[i] <= b_m[i] * b_m[i];
        c_m[i]  <= VMW'(b_m[i]);
        d_m[i]  <= c_m[i];
      end
      d_n2 <= N2W'(c_sq[0]) + N2W'(c_sq[1]) + N2W'(c_sq[2]) + N2W'(c_sq[3]);
    end
  end

  // ---------------- normalize: squared norm into [2^60, 2^62) ----------------
  logic [N2W-1:0] nz_n [0:NST-1];
  logic [VMW-1:0] nz_m [0:NST-1][4];

  for (genvar k = 0; k < NST; k++) begin : g_norm
    localparam int S = 16 >> k;
    logic [N2W-1:0] in_n;
    logic [VMW-1:0] in_m [4];
    if (k == 0) begin : g_first
      assign in_n = d_n2;
      for (genvar i = 0; i < 4; i++) begin : g_l
        assign in_m[i] = d_m[i];
      end
    end else begin : g_next
      assign in_n = nz_n[k-1];
      for (genvar i = 0; i < 4; i++) begin : g_l
        assign in_m[i] = nz_m[k-1][i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (in_n[N2W-1 -: 2*S] == '0) begin
          nz_n[k] <= in_n << (2 * S);
          for (int i = 0; i < 4; i++) nz_m[k][i] <= in_m[i] << S;
        end else begin
          nz_n[k] <= in_n;
          for (int i = 0; i < 4; i++) nz_m[k][i] <= in_m[i];
        end
      end
    end
  end

  // ---------------- integer square root, one bit per stage ----------------
  logic [N2W-1:0] sq_n [0:SST-1];
  logic [N2W-1:0] sq_r [0:SST-1];
  logic [VMW-1:0] sq_m [0:SST-1][4];

  for (genvar s = 0; s < SST; s++) begin : g_sqrt
    localparam logic [N2W-1:0] SBIT = N2W'(1) << (N2W - 2 - 2 * s);
    logic [N2W-1:0] in_n, in_r, t;
    logic [VMW-1:0] in_m [4];
    if (s == 0) begin : g_first
      assign in_n = nz_n[NST-1];
      assign in_r = '0;
      for (genvar i = 0; i < 4; i++) begin : g_l
        assign in_m[i] = nz_m[NST-1][i];
      end
    end else begin : g_next
      assign in_n = sq_n[s-1];
      assign in_r = sq_r[s-1];
      for (genvar i = 0; i < 4; i++) begin : g_l
        assign in_m[i] = sq_m[s-1][i];
      end
    end
    assign t = in_r + SBIT;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 4; i++) sq_m[s][i] <= in_m[i];
        if (in_n >= t) begin
          sq_n[s] <= in_n - t;
          sq_r[s] <= (in_r >> 1) + SBIT;
        end else begin
          sq_n[s] <= in_n;
          sq_r[s] <= in_r >> 1;
        end
      end
    end
  end

  // ---------------- divide each component by the norm ----------------
  logic [QW-1:0] q [4];

  for (genvar i = 0; i < 4; i++) begin : g_div
    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk  (clk),
      .en   (en),
      .mag  (sq_m[SST-1][i]),
      .norm (sq_r[SST-1][NRMW-1:0]),
      .q    (q[i])
    );
  end

  // ---------------- sign, saturate, output register ----------------
  logic signed [DW-1:0] res_c [4];
  logic signed [DW-1:0] o_q [4];
  rmq_pkg::branch_t     o_br;
  logic                 o_deg;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (sd[LAT-1].deg) begin
        res_c[i] = '0;
      end else if (sd[LAT-1].neg[i]) begin
        res_c[i] = (q[i] > QW'(32768)) ? DW'(-32768) : DW'(QW'(0) - q[i]);
      end else begin
        res_c[i] = (q[i] > QW'(32767)) ? DW'(32767) : DW'(q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) o_q[i] <= res_c[i];
      o_br  <= sd[LAT-1].br;
      o_deg <= sd[LAT-1].deg;
    end
  end

  // valid bits and per-item flags travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 1; p <= LAT; p++) vv[p] <= 1'b0;
    end else if (en) begin
      vv[1] <= mat.valid;
      for (int p = 2; p <= LAT; p++) vv[p] <= vv[p-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= side_c;
      for (int p = 2; p <= LAT - 1; p++) sd[p] <= sd[p-1];
    end
  end

  assign quat.valid       = vv[LAT];
  assign quat.quat_w      = o_q[0];
  assign quat.quat_x      = o_q[1];
  assign quat.quat_y      = o_q[2];
  assign quat.quat_z      = o_q[3];
  assign quat.branch_used = o_br;
  assign quat.degenerate  = o_deg;

endmodule

[src/rmq_div.sv]
// Pipelined restoring divider: round(mag * 2^FRAC_BITS / norm), clipped to QW bits.
`timescale 1ns / 1ps

module rmq_div #(
  parameter int FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rmq_pkg::VMW-1:0]      mag,
  input  logic [rmq_pkg::NRMW-1:0]     norm,
  output logic [rmq_pkg::QW-1:0]       q
);

  localparam int QW = rmq_pkg::QW;
  localparam int NW = rmq_pkg::VMW + FRAC_BITS + 1;
  localparam int RW = rmq_pkg::NRMW + QW;
  localparam int CW = (NW > RW) ? NW : RW;

  logic [CW-1:0] num;
  logic [CW-1:0] lim;

  logic [RW-1:0]               rem [0:QW];
  logic [rmq_pkg::NRMW-1:0]    dn  [0:QW];
  logic [QW-1:0]               qb  [0:QW];
  logic                        sat [0:QW];

  // numerator with half the divisor added for round-to-nearest
  assign num = (CW'(mag) << FRAC_BITS) + CW'(norm >> 1);
  assign lim = CW'(norm) << QW;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num[RW-1:0];
      dn[0]  <= norm;
      qb[0]  <= '0;
      sat[0] <= (num >= lim);
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int K = QW - 1 - j;
    logic [RW-1:0] sub;
    assign sub = RW'(dn[j]) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        dn[j+1]  <= dn[j];
        sat[j+1] <= sat[j];
        if (rem[j] >= sub) begin
          rem[j+1] <= rem[j] - sub;
          qb[j+1]  <= qb[j] | (QW'(1) << K);
        end else begin
          rem[j+1] <= rem[j];
          qb[j+1]  <= qb[j];
        end
      end
    end
  end

  assign q = sat[QW] ? '1 : qb[QW];

endmodule
